// File: sv/lwr_pkg.sv
package lwr_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int INC_W          = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC = 3'd0,
    REG_MODE      = 3'd1,
    REG_SINE      = 3'd2,
    REG_GUARD     = 3'd3,
    REG_SEED      = 3'd4
  } lwr_reg_t;

  // Rungler feedback source. The unused fourth code behaves as MODE_KEEP.
  typedef enum logic [1:0] {
    MODE_KEEP   = 2'd0,
    MODE_INVERT = 2'd1,
    MODE_RANDOM = 2'd2
  } lwr_mode_t;

  localparam logic EVT_TICK  = 1'b0;
  localparam logic EVT_RESET = 1'b1;

  localparam logic [INC_W-1:0] PHASE_INC_RST = 16'd256;
  localparam logic [1:0]       MODE_RST      = MODE_INVERT;
  localparam logic             SINE_RST      = 1'b0;
  localparam logic             GUARD_RST     = 1'b1;
  localparam logic [7:0]       PREV_HB_RST   = 8'hFF;

  typedef struct packed {
    logic [INC_W-1:0] phase_inc;
    logic [1:0]       mode;
    logic             sine_en;
    logic             guard;
  } lwr_cfg_t;

  typedef struct packed {
    logic event_kind;
    logic random_bit;
  } lwr_item_t;

  typedef struct packed {
    logic       flop;
    logic [7:0] rungler_level;
    logic [7:0] high_byte;
  } lwr_res_t;

  localparam logic [7:0] LEVEL_MAP [8] = '{
    8'd0, 8'd80, 8'd120, 8'd150, 8'd180, 8'd200, 8'd220, 8'd255
  };

  localparam logic [7:0] SINE_MAP [256] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd5, 8'd5,
    8'd6, 8'd6, 8'd6, 8'd7, 8'd8, 8'd8, 8'd9, 8'd9, 8'd10, 8'd10, 8'd11, 8'd12,
    8'd12, 8'd13, 8'd14, 8'd14, 8'd15, 8'd16, 8'd17, 8'd17,
    8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27,
    8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34,
    8'd35, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd45, 8'd46, 8'd47,
    8'd48, 8'd49, 8'd51, 8'd52, 8'd53, 8'd54, 8'd56,
    8'd57, 8'd58, 8'd60, 8'd61, 8'd62, 8'd64, 8'd65, 8'd66, 8'd68, 8'd69, 8'd71,
    8'd72, 8'd73, 8'd75, 8'd76, 8'd78, 8'd79, 8'd81,
    8'd82, 8'd84, 8'd85, 8'd87, 8'd88, 8'd90, 8'd91, 8'd93, 8'd94, 8'd96, 8'd97,
    8'd99, 8'd100, 8'd102, 8'd103, 8'd105, 8'd106,
    8'd108, 8'd109, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117, 8'd119, 8'd120,
    8'd122, 8'd124, 8'd125, 8'd127, 8'd128,
    8'd130, 8'd131, 8'd133, 8'd135, 8'd136, 8'd138, 8'd139, 8'd141, 8'd142,
    8'd144, 8'd146, 8'd147, 8'd149, 8'd150,
    8'd152, 8'd153, 8'd155, 8'd156, 8'd158, 8'd159, 8'd161, 8'd162, 8'd164,
    8'd165, 8'd167, 8'd168, 8'd170, 8'd171,
    8'd173, 8'd174, 8'd176, 8'd177, 8'd179, 8'd180, 8'd182, 8'd183, 8'd184,
    8'd186, 8'd187, 8'd189, 8'd190, 8'd191,
    8'd193, 8'd194, 8'd195, 8'd197, 8'd198, 8'd199, 8'd201, 8'd202, 8'd203,
    8'd204, 8'd206, 8'd207, 8'd208, 8'd209,
    8'd210, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd220,
    8'd221, 8'd222, 8'd223, 8'd224, 8'd225,
    8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232, 8'd232, 8'd233,
    8'd234, 8'd235, 8'd236, 8'd237, 8'd238,
    8'd238, 8'd239, 8'd240, 8'd241, 8'd241, 8'd242, 8'd243, 8'd243, 8'd244,
    8'd245, 8'd245, 8'd246, 8'd246, 8'd247,
    8'd247, 8'd248, 8'd249, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251,
    8'd252, 8'd252, 8'd252, 8'd253, 8'd253,
    8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  // Level from register bits 5, 3 and 0 (bit 0 is the index LSB).
  function automatic logic [7:0] level_of(input logic [7:0] r);
    logic [2:0] idx;
    idx = {r[5], r[3], r[0]};
    return LEVEL_MAP[idx];
  endfunction

endpackage

// File: sv/lwr_if.sv
interface lwr_in_if;
  logic valid;
  logic ready;
  logic event_kind;
  logic random_bit;

  modport source (output valid, output event_kind, output random_bit, input ready);
  modport sink   (input valid, input event_kind, input random_bit, output ready);
endinterface

interface lwr_out_if;
  logic       valid;
  logic       ready;
  logic       square_out;
  logic [7:0] rungler_level;
  logic [7:0] lfo_level;

  modport source (output valid, output square_out, output rungler_level,
                  output lfo_level, input ready);
  modport sink   (input valid, input square_out, input rungler_level,
                  input lfo_level, output ready);
endinterface

// File: sv/lfo_with_rungler_core.sv
// Phase-accumulator LFO with a rungler shift register. Every request on the
// input channel is one event: a timer tick (event_kind 0) adds the phase
// increment to the phase, and an external reset (event_kind 1) clears the
// phase and sets the square flag. When the phase high byte wraps, the square
// flag toggles and the 8-bit rungler register shifts left, fed from its top
// bit, the inverted top bit or the request's random_bit according to the
// rungler mode; a reset event steps the register as well. With the double
// step guard on, a stepping event right after another one leaves the
// register alone. Each request yields exactly one result request carrying
// the square flag, the rungler level (register bits 5, 3, 0 through an
// eight-entry table, held from the last step) and the LFO byte, optionally
// sine-shaped and inverted while the flag is set. The block accepts one
// request per clock cycle while the result channel does not stall; an
// accepted request goes into the input register and from there into the
// result register, from which its result is offered. Throughput is set by
// the single input register and the result register, which hold one
// request each, and backpressure on the result channel stalls both.
// Configuration is written through cfg_we, cfg_index and cfg_wdata, only
// while the block is idle: a rule for the user that the block does not
// enforce. Writing the seed register loads the rungler register at once.
module lfo_with_rungler_core #(
  parameter int PHASE_BITS = lwr_pkg::PHASE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lwr_in_if.sink                           in_ch,
  lwr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [lwr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lwr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lwr_pkg::*;

  // Configuration registers.
  lwr_cfg_t cfg_r;

  // Input register: one accepted request waiting for the state update.
  logic      s1_valid_r;
  lwr_item_t s1_item_r;

  // Result register.
  logic       out_valid_r;
  logic       out_square_r;
  logic [7:0] out_rlevel_r;
  logic [7:0] out_lfo_r;

  logic       advance;
  logic       in_take;
  logic       seed_load;
  lwr_res_t   res;
  logic [7:0] lfo_level;

  // The input register moves into the result register whenever the result
  // slot is empty or is being emptied in the same cycle.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign seed_load   = cfg_we && (cfg_index == REG_SEED);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_inc <= PHASE_INC_RST;
      cfg_r.mode      <= MODE_RST;
      cfg_r.sine_en   <= SINE_RST;
      cfg_r.guard     <= GUARD_RST;
    end else if (cfg_we) begin
      unique case (lwr_reg_t'(cfg_index))
        REG_PHASE_INC: cfg_r.phase_inc <= cfg_wdata[INC_W-1:0];
        REG_MODE:      cfg_r.mode      <= cfg_wdata[1:0];
        REG_SINE:      cfg_r.sine_en   <= cfg_wdata[0];
        REG_GUARD:     cfg_r.guard     <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.event_kind <= in_ch.event_kind;
      s1_item_r.random_bit <= in_ch.random_bit;
    end
  end

  lwr_step #(
    .PHASE_BITS(PHASE_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .seed_load (seed_load),
    .seed_value(cfg_wdata[7:0]),
    .step_en   (s1_valid_r && advance),
    .item      (s1_item_r),
    .res       (res)
  );

  lwr_shape u_shape (
    .high_byte(res.high_byte),
    .sine_en  (cfg_r.sine_en),
    .flop     (res.flop),
    .lfo_level(lfo_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_square_r <= res.flop;
      out_rlevel_r <= res.rungler_level;
      out_lfo_r    <= lfo_level;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.square_out    = out_square_r;
  assign out_ch.rungler_level = out_rlevel_r;
  assign out_ch.lfo_level     = out_lfo_r;

endmodule

// File: sv/lwr_step.sv
module lwr_step #(
  parameter int PHASE_BITS = lwr_pkg::PHASE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lwr_pkg::lwr_cfg_t  cfg,
  input  logic               seed_load,
  input  logic [7:0]         seed_value,
  input  logic               step_en,
  input  lwr_pkg::lwr_item_t item,
  output lwr_pkg::lwr_res_t  res
);
  import lwr_pkg::*;

  localparam int SUM_W = (PHASE_BITS > INC_W) ? PHASE_BITS : INC_W;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [7:0]            prev_hb_r;
  logic                  flop_r, flop_nxt;
  logic [7:0]            rreg_r, rreg_nxt;
  logic                  stepped_r;
  logic [7:0]            level_r, level_nxt;

  logic [SUM_W-1:0] sum;
  logic [7:0]       hb;
  logic             is_reset;
  logic             wrap;
  logic             do_step;
  logic             fb;

  always_comb begin
    is_reset = (item.event_kind == EVT_RESET);
    sum = SUM_W'(phase_r) + SUM_W'(cfg.phase_inc);
    phase_nxt = is_reset ? '0 : sum[PHASE_BITS-1:0];
    hb = phase_nxt[PHASE_BITS-1 -: 8];
    wrap = (hb < prev_hb_r) || is_reset;

    if (is_reset) begin
      flop_nxt = 1'b1;
    end else begin
      flop_nxt = wrap ? ~flop_r : flop_r;
    end

    case (cfg.mode)
      MODE_INVERT: fb = ~rreg_r[7];
      MODE_RANDOM: fb = item.random_bit;
      default:     fb = rreg_r[7];
    endcase

    do_step = wrap && !(cfg.guard && stepped_r);
    rreg_nxt = do_step ? {rreg_r[6:0], fb} : rreg_r;
    level_nxt = do_step ? level_of(rreg_nxt) : level_r;

    res.flop = flop_nxt;
    res.rungler_level = level_nxt;
    res.high_byte = hb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      prev_hb_r <= PREV_HB_RST;
      flop_r    <= 1'b0;
      rreg_r    <= '0;
      stepped_r <= 1'b0;
      level_r   <= '0;
    end else if (seed_load) begin
      rreg_r <= seed_value;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      prev_hb_r <= hb;
      flop_r    <= flop_nxt;
      rreg_r    <= rreg_nxt;
      stepped_r <= wrap;
      level_r   <= level_nxt;
    end
  end

endmodule

// File: sv/lwr_shape.sv
module lwr_shape (
  input  logic [7:0] high_byte,
  input  logic       sine_en,
  input  logic       flop,
  output logic [7:0] lfo_level
);
  import lwr_pkg::*;

  logic [7:0] shaped;

  always_comb begin
    shaped = sine_en ? SINE_MAP[high_byte] : high_byte;
    lfo_level = flop ? ~shaped : shaped;
  end

endmodule

// File: sv/lwr_checker.sv
module lwr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_event_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_square_out,
  input logic [7:0] out_rungler_level,
  input logic [7:0] out_lfo_level
);
  import lwr_pkg::*;

  // No result may be pending right after reset is released.
  a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A reset event that moves on unstalled shows a set square flag.
  a_reset_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_event_kind == EVT_RESET)) ##1
    (!out_valid || out_ready) |=> (out_valid && out_square_out))
    else $error("reset event did not yield a set square flag");

  // A stalled result stays offered.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
    ($stable(out_square_out) && $stable(out_rungler_level) && $stable(out_lfo_level)))
    else $error("result payload changed while stalled");

endmodule

bind lfo_with_rungler_core lwr_checker u_lwr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_event_kind    (in_ch.event_kind),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_square_out   (out_ch.square_out),
  .out_rungler_level(out_ch.rungler_level),
  .out_lfo_level    (out_ch.lfo_level)
);

// File: dv/lfo_check_pkg.sv
package lfo_check_pkg;
  import lwr_pkg::*;

  // Feedback code that the block leaves unused; it must act like MODE_KEEP.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Register indexes past the last register; writes to them change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  class lfo_tracker;
    logic [INC_W-1:0]          phase_inc;
    logic [1:0]                fb_mode;
    logic                      sine_on;
    logic                      guard_on;
    logic [PHASE_BITS_DEF-1:0] phase;
    logic [7:0]                last_high;
    logic                      flag;
    logic [7:0]                shreg;
    logic                      was_step;
    logic [7:0]                held_level;
    lwr_res_t                  pending_outputs[$];

    function new();
      phase_inc  = PHASE_INC_RST;
      fb_mode    = MODE_RST;
      sine_on    = SINE_RST;
      guard_on   = GUARD_RST;
      phase      = '0;
      last_high  = PREV_HB_RST;
      flag       = 1'b0;
      shreg      = 8'h00;
      was_step   = 1'b0;
      held_level = 8'h00;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PHASE_INC: phase_inc = data[INC_W-1:0];
        REG_MODE:      fb_mode   = data[1:0];
        REG_SINE:      sine_on   = data[0];
        REG_GUARD:     guard_on  = data[0];
        REG_SEED:      shreg     = data[7:0];
        default: ;
      endcase
    endfunction

    // Advances the local copy of the LFO by one accepted request.
    function void note_event(lwr_item_t req);
      logic [7:0] high;
      logic [7:0] lfo;
      logic       fb;
      lwr_res_t   want;
      if (req.event_kind == EVT_RESET) begin
        phase = '0;
        flag  = 1'b1;
      end else begin
        phase = phase + phase_inc;
      end
      high = phase[PHASE_BITS_DEF-1 -: 8];
      if (high < last_high || req.event_kind == EVT_RESET) begin
        if (req.event_kind != EVT_RESET) flag = ~flag;
        if (!(guard_on && was_step)) begin
          case (fb_mode)
            MODE_INVERT: fb = ~shreg[7];
            MODE_RANDOM: fb = req.random_bit;
            default:     fb = shreg[7];
          endcase
          shreg      = {shreg[6:0], fb};
          held_level = LEVEL_MAP[{shreg[5], shreg[3], shreg[0]}];
        end
        was_step = 1'b1;
      end else begin
        was_step = 1'b0;
      end
      last_high = high;
      lfo = sine_on ? SINE_MAP[high] : high;
      if (flag) lfo = ~lfo;
      want.flop          = flag;
      want.rungler_level = held_level;
      want.high_byte     = lfo;
      pending_outputs.push_back(want);
    endfunction

    function int check_output(logic square, logic [7:0] rlevel, logic [7:0] llevel);
      lwr_res_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result square=%0b rungler=%0d lfo=%0d",
                 $time, square, rlevel, llevel);
        return 1;
      end
      want = pending_outputs.pop_front();
      if ({square, rlevel, llevel} !== want) begin
        $display("%0t: mismatch expected square=%0b rungler=%0d lfo=%0d, got square=%0b rungler=%0d lfo=%0d",
                 $time, want.flop, want.rungler_level, want.high_byte,
                 square, rlevel, llevel);
        return 1;
      end
      return 0;
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

endpackage

// File: dv/tb_lfo_with_rungler_core.sv
module tb_lfo_with_rungler_core;
  import lwr_pkg::*;
  import lfo_check_pkg::*;

  // Watchdog bound on the run length, far above what the slowest run needs.
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PHASES    = 8;
  localparam int EVENTS_PER_PHASE = 135;
  localparam int END_WAIT         = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lwr_in_if  in_bus ();
  lwr_out_if out_bus ();

  // Chance in percent that the sender idles or the receiver stalls on a cycle.
  int idle_pct;
  int stall_pct;
  int errors;
  int cycles;

  lfo_tracker tracker;

  lfo_with_rungler_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver decides afresh at every falling edge whether to take a result.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Both channels are sampled at the rising edge, where a request moves when
  // valid and ready are high together. Inputs change only at falling edges,
  // so the values seen here are settled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        tracker.note_event(lwr_item_t'({in_bus.event_kind, in_bus.random_bit}));
      end
      if (out_bus.valid && out_bus.ready) begin
        errors += tracker.check_output(out_bus.square_out, out_bus.rungler_level,
                                       out_bus.lfo_level);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** lfo_with_rungler_core: FAILED **");
    $finish;
  end

  // A register write lowers cfg_we and then waits for a further falling edge
  // so that cfg_we never gets two assignments in one time step. The block is
  // idle whenever this runs, so the local copy is updated right away.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one request and returns at the falling edge after it was taken.
  // While idling, the payload is scrambled so that nothing leans on it.
  task automatic send_event(input logic kind, input logic rnd);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid      <= 1'b0;
      in_bus.event_kind <= 1'($urandom_range(1));
      in_bus.random_bit <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.event_kind <= kind;
    in_bus.random_bit <= rnd;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Stops the sender and waits until every expected result has come back,
  // plus a few idle cycles for good measure.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Picks a fresh setting for a random phase. Increments lean toward the
  // extremes; narrow registers get junk in their unused data bits.
  task automatic pick_setup();
    logic [CFG_DATA_W-1:0] data;
    case ($urandom_range(5))
      0:       data = '0;
      1:       data = '1;
      2:       data = CFG_DATA_W'($urandom_range(16'h0FFF, 16'h0100));
      default: data = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_PHASE_INC, data);
    data = CFG_DATA_W'($urandom);
    write_reg(REG_MODE, data);
    data = CFG_DATA_W'($urandom);
    write_reg(REG_SINE, data);
    data = CFG_DATA_W'($urandom);
    write_reg(REG_GUARD, data);
    if ($urandom_range(1)) begin
      data = CFG_DATA_W'($urandom);
      write_reg(REG_SEED, data);
    end
    if ($urandom_range(3) == 0) begin
      data = CFG_DATA_W'($urandom);
      write_reg(CFG_IDX_W'($urandom_range(REG_NONE_HI, REG_NONE_LO)), data);
    end
  endtask

  initial begin
    logic kind;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.event_kind = EVT_TICK;
    in_bus.random_bit = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    errors            = 0;
    tracker           = new();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: the first tick already wraps past the 255 start value,
    // and back-to-back resets exercise the double step guard.
    send_event(EVT_TICK,  1'b0);
    send_event(EVT_TICK,  1'b1);
    send_event(EVT_RESET, 1'b1);
    send_event(EVT_RESET, 1'b0);
    send_event(EVT_TICK,  1'b0);
    send_event(EVT_TICK,  1'b1);
    settle();

    // Largest increment moves the phase back by one per tick, so a wrap comes only
    // when the low byte rolls under zero; the guard is off, so every stepping event shifts in the random bit.
    write_reg(REG_PHASE_INC, 16'hFFFF);
    write_reg(REG_MODE, {14'h3FFF, MODE_RANDOM});
    write_reg(REG_GUARD, 16'h0000);
    write_reg(REG_SINE, 16'hFFFF);
    write_reg(REG_SEED, 16'hFFA5);
    send_event(EVT_TICK,  1'b1);
    send_event(EVT_TICK,  1'b0);
    send_event(EVT_RESET, 1'b1);
    send_event(EVT_RESET, 1'b0);
    send_event(EVT_TICK,  1'b1);
    send_event(EVT_TICK,  1'b0);
    settle();

    // Zero increment with the spare feedback code; writes past the last
    // register must leave the setting alone.
    write_reg(REG_PHASE_INC, 16'h0000);
    write_reg(REG_MODE, {14'h0000, MODE_SPARE});
    write_reg(REG_SEED, 16'h00FF);
    write_reg(REG_SINE, 16'h0000);
    write_reg(REG_GUARD, 16'h0001);
    write_reg(REG_NONE_LO, 16'hFFFF);
    write_reg(REG_NONE_HI, 16'h0000);
    send_event(EVT_TICK,  1'b0);
    send_event(EVT_RESET, 1'b1);
    send_event(EVT_TICK,  1'b0);
    send_event(EVT_TICK,  1'b1);
    settle();

    // Half-scale increment wraps every second tick; plain feedback of bit 7.
    write_reg(REG_PHASE_INC, 16'h8000);
    write_reg(REG_MODE, {14'h2AAA, MODE_KEEP});
    write_reg(REG_SEED, 16'h0080);
    write_reg(REG_SINE, 16'h0001);
    write_reg(REG_GUARD, 16'hFFFE);
    send_event(EVT_TICK,  1'b1);
    send_event(EVT_TICK,  1'b0);
    send_event(EVT_RESET, 1'b1);
    send_event(EVT_TICK,  1'b0);
    send_event(EVT_TICK,  1'b1);
    send_event(EVT_RESET, 1'b0);
    send_event(EVT_RESET, 1'b1);
    settle();

    // Random phases cycle through the flow-control patterns: free running,
    // a lazy sender, a lazy receiver, and both at once.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_setup();
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 62; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int i = 0; i < EVENTS_PER_PHASE; i++) begin
        // Mostly ticks; a reset about one request in eight.
        kind = ($urandom_range(7) == 0) ? EVT_RESET : EVT_TICK;
        send_event(kind, 1'($urandom_range(1)));
        // In phase 5 only, the sender once holds off mid-phase until the pipeline is empty.
        if (p == 5 && i == EVENTS_PER_PHASE / 2) settle();
      end
      settle();
    end

    // Final drain with a bound; whatever is still expected counts as lost.
    in_bus.valid <= 1'b0;
    for (int w = 0; w < END_WAIT && tracker.pending() != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, tracker.pending());
      errors += tracker.pending();
    end

    if (errors == 0) begin
      $display("** lfo_with_rungler_core: PASSED **");
    end else begin
      $display("** lfo_with_rungler_core: FAILED **");
    end
    $finish;
  end

endmodule
